// ----- hdl/lfr_pkg.sv -----
package lfr_pkg;

  localparam int FRAME_W        = 6;
  localparam int COUNT_W        = 7;
  localparam int CAP_W          = 7;
  localparam int MODE_W         = 2;
  localparam int NUM_FRAMES_DEF = 64;
  localparam int PADDR_W        = 2;
  localparam int PDATA_W        = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET    = 7'd64;
  localparam logic [PADDR_W-1:0] REG_CAPACITY = 2'd0;

  localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PIN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the request beat, clear result fields
    logic push;        // append frame at tail, set its member bit
    logic unmark;      // clear member bit of the latched frame
    logic scan_start;  // read order store at head
    logic scan_next;   // read the next slot after the last one read
    logic set_hole;    // remember the slot just read as the open slot
    logic shift_wr;    // move the slot just read into the open slot
    logic dec;         // drop one from the count
    logic pop;         // report head, advance head, drop one from the count
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              unpin_ok;
    logic              pin_hit;
    logic              empty;
    logic              match;
    logic              last;
  } sts_t;

endpackage

// ----- hdl/lru_frame_replacer.sv -----
// LRU frame replacer for a buffer pool.
//
// Request channel: drive mode and frame_no with start; the beat is taken at a
// clock edge where start is high and busy is low. Modes: unpin appends the
// frame at the tail of the evictable list if it is in range, not yet listed
// and below capacity, pin removes it wherever it stands, victim pops the
// oldest frame, and the spare code reports the count only. Result channel:
// done is high for exactly one cycle with victim_valid, evict_frame and
// evictable_count; the result beat is taken at the edge that ends that cycle.
// The receiver cannot stall, so nothing is ever held back. A new request is
// accepted in the result cycle. A pin that hits is paced by the single read
// port of the order store: one slot is scanned per cycle to find the frame,
// then one slot per cycle is moved down to close the gap.
// Capacity sits at APB offset 0 and may be rewritten only while the block is
// idle. Reset empties the list and clears every member bit at once; capacity
// returns to 64 and the block takes requests in the first cycle after reset.
module lru_frame_replacer #(
  parameter int NUM_FRAMES = lfr_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfr_pkg::PADDR_W-1:0]   paddr,
  input  logic [lfr_pkg::PDATA_W-1:0]   pwdata,
  output logic [lfr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // request
  input  logic                          start,
  input  logic [lfr_pkg::MODE_W-1:0]    mode,
  input  logic [lfr_pkg::FRAME_W-1:0]   frame_no,
  output logic                          busy,
  // result
  output logic                          done,
  output logic                          victim_valid,
  output logic [lfr_pkg::FRAME_W-1:0]   evict_frame,
  output logic [lfr_pkg::COUNT_W-1:0]   evictable_count
);

  logic [lfr_pkg::CAP_W-1:0] capacity;
  lfr_pkg::cmd_t             cmd;
  lfr_pkg::sts_t             sts;

  // APB register: no wait states, write on the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfr_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == lfr_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[lfr_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lfr_pkg::REG_CAPACITY) begin
      prdata = lfr_pkg::PDATA_W'(capacity);
    end
  end

  // Sequencer: decodes the latched request and steps the datapath.
  lfr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Order store (circular list in RAM), member bits, count and result hold.
  lfr_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .mode            (mode),
    .frame_no        (frame_no),
    .capacity        (capacity),
    .victim_valid    (victim_valid),
    .evict_frame     (evict_frame),
    .evictable_count (evictable_count)
  );

endmodule

// ----- hdl/lfr_ram.sv -----
module lfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/lfr_datapath.sv -----
module lfr_datapath #(
  parameter int NUM_FRAMES = lfr_pkg::NUM_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lfr_pkg::cmd_t                cmd,
  output lfr_pkg::sts_t                sts,
  input  logic [lfr_pkg::MODE_W-1:0]   mode,
  input  logic [lfr_pkg::FRAME_W-1:0]  frame_no,
  input  logic [lfr_pkg::CAP_W-1:0]    capacity,
  output logic                         victim_valid,
  output logic [lfr_pkg::FRAME_W-1:0]  evict_frame,
  output logic [lfr_pkg::COUNT_W-1:0]  evictable_count
);

  localparam int AW     = $clog2(NUM_FRAMES);
  localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int ID_N   = 2 ** lfr_pkg::FRAME_W;
  localparam int MEMB_N = (NUM_FRAMES < ID_N) ? NUM_FRAMES : ID_N;
  localparam int MW     = $clog2(MEMB_N);
  localparam int CMPW   = (CNT_W > lfr_pkg::CAP_W) ? CNT_W : lfr_pkg::CAP_W;

  logic [lfr_pkg::MODE_W-1:0]  op_mode;
  logic [lfr_pkg::FRAME_W-1:0] op_frame;
  logic [AW-1:0]               head;
  logic [CNT_W-1:0]            count;
  logic [MEMB_N-1:0]           member;
  logic [AW-1:0]               rd_ptr;
  logic [CNT_W-1:0]            rd_rel;
  logic [AW-1:0]               hole;
  logic                        vict_valid;
  logic [lfr_pkg::FRAME_W-1:0] vict_frame;

  logic                        in_range;
  logic                        member_hit;
  logic [AW:0]                 tail_sum;
  logic [AW-1:0]               tail;
  logic [AW-1:0]               rd_next;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [lfr_pkg::FRAME_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [lfr_pkg::FRAME_W-1:0] ram_rdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(NUM_FRAMES - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    in_range   = int'(op_frame) < NUM_FRAMES;
    member_hit = in_range && member[MW'(op_frame)];
    tail_sum   = {1'b0, head} + (AW+1)'(count);
    if (tail_sum >= (AW+1)'(NUM_FRAMES)) begin
      tail = AW'(tail_sum - (AW+1)'(NUM_FRAMES));
    end else begin
      tail = tail_sum[AW-1:0];
    end
    rd_next   = wrap_inc(rd_ptr);
    ram_raddr = cmd.scan_start ? head : rd_next;
    ram_we    = cmd.push || cmd.shift_wr;
    ram_waddr = cmd.push ? tail : hole;
    ram_wdata = cmd.push ? op_frame : ram_rdata;
  end

  always_comb begin
    sts.mode     = op_mode;
    sts.unpin_ok = in_range && !member_hit && (CMPW'(count) < CMPW'(capacity)) &&
                   (int'(count) < NUM_FRAMES);
    sts.pin_hit  = member_hit;
    sts.empty    = (count == '0);
    sts.match    = (ram_rdata == op_frame);
    sts.last     = ((rd_rel + 1'b1) == count);
  end

  lfr_ram #(
    .WIDTH (lfr_pkg::FRAME_W),
    .DEPTH (NUM_FRAMES)
  ) u_order (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      member     <= '0;
      vict_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_mode    <= mode;
        op_frame   <= frame_no;
        vict_valid <= 1'b0;
        vict_frame <= '0;
      end
      if (cmd.push) begin
        member[MW'(op_frame)] <= 1'b1;
        count                 <= count + 1'b1;
      end
      if (cmd.unmark) begin
        member[MW'(op_frame)] <= 1'b0;
      end
      if (cmd.scan_start) begin
        rd_ptr <= head;
        rd_rel <= '0;
      end
      if (cmd.scan_next) begin
        rd_ptr <= rd_next;
        rd_rel <= rd_rel + 1'b1;
      end
      if (cmd.set_hole) begin
        hole <= rd_ptr;
      end
      if (cmd.dec) begin
        count <= count - 1'b1;
      end
      if (cmd.pop) begin
        vict_valid <= 1'b1;
        vict_frame <= ram_rdata;
        if (int'(ram_rdata) < MEMB_N) begin
          member[MW'(ram_rdata)] <= 1'b0;
        end
        head  <= wrap_inc(head);
        count <= count - 1'b1;
      end
    end
  end

  assign victim_valid    = vict_valid;
  assign evict_frame     = vict_frame;
  assign evictable_count = lfr_pkg::COUNT_W'(count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= NUM_FRAMES)
    else $error("evictable count above frame total");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> count == $past(count) + 1'b1)
    else $error("push did not grow the count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop || cmd.dec) |-> count != '0)
    else $error("removal from an empty order store");

endmodule

// ----- hdl/lfr_ctrl.sv -----
module lfr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lfr_pkg::sts_t sts,
  output lfr_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_SHIFT,
    ST_VREAD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        unique case (sts.mode)
          lfr_pkg::MODE_UNPIN: begin
            cmd.push = sts.unpin_ok;
          end
          lfr_pkg::MODE_PIN: begin
            if (sts.pin_hit) begin
              cmd.unmark     = 1'b1;
              cmd.scan_start = 1'b1;
              state_next     = ST_SEARCH;
            end
          end
          lfr_pkg::MODE_VICTIM: begin
            if (!sts.empty) begin
              cmd.scan_start = 1'b1;
              state_next     = ST_VREAD;
            end
          end
          lfr_pkg::MODE_NOP: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SEARCH: begin
        cmd.scan_next = 1'b1;
        if (sts.match) begin
          cmd.set_hole = 1'b1;
          if (sts.last) begin
            cmd.dec    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        cmd.shift_wr  = 1'b1;
        cmd.set_hole  = 1'b1;
        cmd.scan_next = 1'b1;
        if (sts.last) begin
          cmd.dec    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_VREAD: begin
        cmd.pop    = 1'b1;
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state != ST_IDLE) && (state_next == ST_IDLE);
    end
  end

  assign busy = (state != ST_IDLE);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.pop, cmd.shift_wr}))
    else $error("conflicting order store updates");

endmodule
